// ===== rtl/core/ggm_pkg.sv =====
// ggm_pkg: widths, register indexes and arithmetic helpers for the gray
// gradient magnitude stream
// no dependencies
package ggm_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = ColW + 1;
  localparam int unsigned RowW     = 16;
  localparam int unsigned PixW     = 8;
  localparam int unsigned SumW     = 18;
  localparam int unsigned HalfW    = PixW - 1;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [WidthW-1:0] WidthReset  = WidthW'(1024);
  localparam logic [RowW-1:0]   HeightReset = RowW'(768);

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 1'b0,
    CfgImageHeight = 1'b1
  } cfg_idx_e;

  // weighted sum 300r + 590g + 110b, at most 255000
  function automatic logic [SumW-1:0] gray_sum(input logic [PixW-1:0] r,
                                               input logic [PixW-1:0] g,
                                               input logic [PixW-1:0] b);
    return SumW'(r) * SumW'(300) + SumW'(g) * SumW'(590) + SumW'(b) * SumW'(110);
  endfunction

  // floor(sum / 1000) as floor(floor(sum / 8) / 125) by reciprocal
  function automatic logic [PixW-1:0] gray_div(input logic [SumW-1:0] sum);
    logic [30:0] prod;
    prod = 31'(sum >> 3) * 31'd33555;
    return prod[29:22];
  endfunction

  function automatic logic [HalfW-1:0] half_abs_diff(input logic [PixW-1:0] a,
                                                     input logic [PixW-1:0] b);
    logic [PixW-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d[PixW-1:1];
  endfunction

endpackage

// ===== rtl/core/ggm_pix_if.sv =====
// ggm_pix_if: pixel request channel, valid/ready with rgb payload
// depends on ggm_pkg
interface ggm_pix_if;
  logic                     valid;
  logic                     ready;
  logic [ggm_pkg::PixW-1:0] red_level;
  logic [ggm_pkg::PixW-1:0] green_level;
  logic [ggm_pkg::PixW-1:0] blue_level;

  modport source (output valid, output red_level, output green_level,
                  output blue_level, input ready);
  modport sink (input valid, input red_level, input green_level,
                input blue_level, output ready);
endinterface

// ===== rtl/core/ggm_res_if.sv =====
// ggm_res_if: gradient result channel, valid/ready with result payload
// depends on ggm_pkg
interface ggm_res_if;
  logic                     valid;
  logic                     ready;
  logic [ggm_pkg::PixW-1:0] gradient_level;
  logic [ggm_pkg::RowW-1:0] out_row;
  logic [ggm_pkg::ColW-1:0] out_col;
  logic                     run_last;
  logic                     frame_done;

  modport source (output valid, output gradient_level, output out_row,
                  output out_col, output run_last, output frame_done,
                  input ready);
  modport sink (input valid, input gradient_level, input out_row,
                input out_col, input run_last, input frame_done,
                output ready);
endinterface

// ===== rtl/core/gray_gradient_magnitude_stream.sv =====
// gray_gradient_magnitude_stream: rgb to gray, line store, central-difference
// gradient magnitude; depends on ggm_pkg, ggm_pix_if, ggm_res_if
// path: an accepted pixel goes to the stage-1 register, its result to out_q
// throughput: one pixel per cycle unless the output stalls; the single result
//   register moves one result per cycle; a two-result last-row pixel stalls input
// reset: counters, handshake state cleared, size 1024 x 768; line store not cleared
module gray_gradient_magnitude_stream (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ggm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [ggm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  ggm_pix_if.sink                          pix_i,
  ggm_res_if.source                        grad_o
);

  typedef struct packed {
    logic [ggm_pkg::SumW-1:0] sum;
    logic [ggm_pkg::RowW-1:0] row;
    logic [ggm_pkg::ColW-1:0] col;
    logic                     has_prev;
    logic                     last_row;
    logic                     frame_end;
    logic                     interior;
  } s1_t;

  typedef struct packed {
    logic [ggm_pkg::PixW-1:0] gradient;
    logic [ggm_pkg::RowW-1:0] row;
    logic [ggm_pkg::ColW-1:0] col;
    logic                     run_last;
    logic                     frame_done;
  } res_t;

  localparam int unsigned WordW = 2 * ggm_pkg::PixW;

  // config registers
  logic [ggm_pkg::WidthW-1:0] width_q;
  logic [ggm_pkg::RowW-1:0]   height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ggm_pkg::WidthReset;
      height_q <= ggm_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (ggm_pkg::cfg_idx_e'(cfg_idx_i))
        ggm_pkg::CfgImageWidth:  width_q  <= cfg_wdata_i[ggm_pkg::WidthW-1:0];
        ggm_pkg::CfgImageHeight: height_q <= cfg_wdata_i[ggm_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  // position and frame flags of the incoming pixel
  logic [ggm_pkg::RowW-1:0]   row_q, row_d;
  logic [ggm_pkg::ColW-1:0]   col_q, col_d;
  logic [ggm_pkg::WidthW-1:0] w_eff;
  logic [ggm_pkg::RowW-1:0]   h_eff;
  logic                       row_end, last_row;
  logic                       in_fire;
  s1_t                        s1_d;

  always_comb begin
    if (width_q == '0) begin
      w_eff = ggm_pkg::WidthW'(1);
    end else if (width_q > ggm_pkg::WidthW'(ggm_pkg::MaxWidth)) begin
      w_eff = ggm_pkg::WidthW'(ggm_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    h_eff    = (height_q == '0) ? ggm_pkg::RowW'(1) : height_q;
    row_end  = ({1'b0, col_q} + ggm_pkg::WidthW'(1)) >= w_eff;
    last_row = ({1'b0, row_q} + (ggm_pkg::RowW + 1)'(1)) >= {1'b0, h_eff};

    s1_d.sum       = ggm_pkg::gray_sum(pix_i.red_level, pix_i.green_level,
                                       pix_i.blue_level);
    s1_d.row       = row_q;
    s1_d.col       = col_q;
    s1_d.has_prev  = row_q != '0;
    s1_d.last_row  = last_row;
    s1_d.frame_end = row_end && last_row;
    s1_d.interior  = (row_q >= ggm_pkg::RowW'(2)) && (row_q < h_eff) &&
                     (col_q != '0) &&
                     (({1'b0, col_q} + ggm_pkg::WidthW'(1)) < w_eff);

    if (row_end) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + ggm_pkg::RowW'(1);
    end else begin
      col_d = col_q + ggm_pkg::ColW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line store: word[j] holds {row two above, row above} at column j
  logic [WordW-1:0]         line_mem [ggm_pkg::MaxWidth];
  logic [ggm_pkg::ColW-1:0] rd_addr_cur, rd_addr_nxt, wr_addr;
  logic [WordW-1:0]         rd_cur_q, rd_nxt_q, fwd_data_q, wr_data;
  logic                     fwd_cur_q, fwd_nxt_q, wr_en;
  logic [WordW-1:0]         cur_word, nxt_word;

  assign rd_addr_cur = col_q;
  assign rd_addr_nxt = col_q + ggm_pkg::ColW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (in_fire) begin
      rd_cur_q   <= line_mem[rd_addr_cur];
      rd_nxt_q   <= line_mem[rd_addr_nxt];
      fwd_cur_q  <= wr_en && (wr_addr == rd_addr_cur);
      fwd_nxt_q  <= wr_en && (wr_addr == rd_addr_nxt);
      fwd_data_q <= wr_data;
    end
  end

  assign cur_word = fwd_cur_q ? fwd_data_q : rd_cur_q;
  assign nxt_word = fwd_nxt_q ? fwd_data_q : rd_nxt_q;

  // stage 1: gray, gradient and result selection
  s1_t                      s1_q;
  logic                     s1_valid_q;
  logic                     sel_q;
  logic [ggm_pkg::PixW-1:0] left_q;
  logic [ggm_pkg::PixW-1:0] s1_gray, top, cur_prev, right, grad_val;
  logic                     emit_prev, has_res, final_res;
  logic                     out_load, out_push, s1_adv;
  res_t                     res_d, out_q;
  logic                     out_valid_q;

  always_comb begin
    s1_gray  = ggm_pkg::gray_div(s1_q.sum);
    top      = cur_word[WordW-1:ggm_pkg::PixW];
    cur_prev = cur_word[ggm_pkg::PixW-1:0];
    right    = nxt_word[ggm_pkg::PixW-1:0];
    grad_val = {1'b0, ggm_pkg::half_abs_diff(right, left_q)} +
               {1'b0, ggm_pkg::half_abs_diff(top, s1_gray)};

    emit_prev = s1_q.has_prev && !sel_q;
    has_res   = s1_q.has_prev || s1_q.last_row;
    final_res = !emit_prev || !s1_q.last_row;

    if (emit_prev) begin
      res_d.gradient   = s1_q.interior ? grad_val : '0;
      res_d.row        = s1_q.row - ggm_pkg::RowW'(1);
      res_d.col        = s1_q.col;
      res_d.run_last   = !s1_q.last_row;
      res_d.frame_done = !s1_q.last_row && s1_q.frame_end;
    end else begin
      res_d.gradient   = '0;
      res_d.row        = s1_q.row;
      res_d.col        = s1_q.col;
      res_d.run_last   = 1'b1;
      res_d.frame_done = s1_q.frame_end;
    end

    out_load = !out_valid_q || grad_o.ready;
    out_push = s1_valid_q && has_res && out_load;
    s1_adv   = s1_valid_q && (!has_res || (out_load && final_res));
    in_fire  = pix_i.valid && pix_i.ready;

    wr_en   = s1_adv;
    wr_addr = s1_q.col;
    wr_data = {cur_prev, s1_gray};
  end

  assign pix_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        sel_q <= 1'b0;
      end else if (out_push) begin
        sel_q <= 1'b1;
      end
      if (out_push) begin
        out_valid_q <= 1'b1;
      end else if (grad_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      left_q <= cur_prev;
    end
    if (out_push) begin
      out_q <= res_d;
    end
  end

  assign grad_o.valid          = out_valid_q;
  assign grad_o.gradient_level = out_q.gradient;
  assign grad_o.out_row        = out_q.row;
  assign grad_o.out_col        = out_q.col;
  assign grad_o.run_last       = out_q.run_last;
  assign grad_o.frame_done     = out_q.frame_done;

endmodule

// ===== verif/gray_gradient_magnitude_stream_tb.sv =====
`timescale 1ns / 1ps
// gray_gradient_magnitude_stream_tb: drives rgb pixel requests with bursts and stalls,
// predicts each gradient result and checks it field by field in a scoreboard class
// depends on ggm_pkg, ggm_pix_if, ggm_res_if and gray_gradient_magnitude_stream
module gray_gradient_magnitude_stream_tb;

  localparam int unsigned HoldCycles = 200;
  localparam int unsigned RandomPixels = 450;
  localparam int unsigned WideRowPixels = 60;

  typedef struct {
    logic [ggm_pkg::PixW-1:0] level;
    logic [ggm_pkg::RowW-1:0] row;
    logic [ggm_pkg::ColW-1:0] col;
    logic                     last;
    logic                     done;
  } gradient_t;

  class gradient_tracker;
    logic [ggm_pkg::PixW-1:0]   above_row [ggm_pkg::MaxWidth];
    logic [ggm_pkg::PixW-1:0]   two_up_row [ggm_pkg::MaxWidth];
    int unsigned                row_pos;
    int unsigned                col_pos;
    logic [ggm_pkg::WidthW-1:0] width_reg;
    logic [ggm_pkg::RowW-1:0]   height_reg;
    gradient_t                  pending_gradients [$];
    int unsigned                mismatches;

    function new();
      row_pos = 0;
      col_pos = 0;
      width_reg = ggm_pkg::WidthReset;
      height_reg = ggm_pkg::HeightReset;
      mismatches = 0;
    endfunction

    function void set_reg(input ggm_pkg::cfg_idx_e idx,
                          input logic [ggm_pkg::CfgDataW-1:0] data);
      if (idx == ggm_pkg::CfgImageWidth) begin
        width_reg = data[ggm_pkg::WidthW-1:0];
      end else begin
        height_reg = data[ggm_pkg::RowW-1:0];
      end
    endfunction

    function int unsigned halved_gap(input int unsigned a, input int unsigned b);
      return (a > b ? a - b : b - a) / 2;
    endfunction

    function void predict_gradients(input logic [ggm_pkg::PixW-1:0] r,
                                    input logic [ggm_pkg::PixW-1:0] g,
                                    input logic [ggm_pkg::PixW-1:0] b);
      int unsigned w, h, gray, grad, i, j;
      bit          last_row, frame_end;
      gradient_t   res;
      w = 32'(width_reg);
      if (w == 0) w = 1;
      if (w > ggm_pkg::MaxWidth) w = ggm_pkg::MaxWidth;
      h = 32'(height_reg);
      if (h == 0) h = 1;
      gray = (300 * 32'(r) + 590 * 32'(g) + 110 * 32'(b)) / 1000;
      i = row_pos;
      j = col_pos;
      last_row = (i + 1 >= h);
      frame_end = (j + 1 >= w) && last_row;
      if (i >= 1) begin
        grad = 0;
        if (i >= 2 && i < h && j >= 1 && j + 1 < w) begin
          grad = halved_gap(32'(above_row[j+1]), 32'(two_up_row[j-1])) +
                 halved_gap(32'(two_up_row[j]), gray);
        end
        res.level = grad[ggm_pkg::PixW-1:0];
        res.row = ggm_pkg::RowW'(i - 1);
        res.col = ggm_pkg::ColW'(j);
        res.last = !last_row;
        res.done = !last_row && frame_end;
        pending_gradients.push_back(res);
      end
      // every last-row pixel also closes its own border result
      if (last_row) begin
        res.level = '0;
        res.row = ggm_pkg::RowW'(i);
        res.col = ggm_pkg::ColW'(j);
        res.last = 1'b1;
        res.done = frame_end;
        pending_gradients.push_back(res);
      end
      if (j < ggm_pkg::MaxWidth) begin
        two_up_row[j] = above_row[j];
        above_row[j] = gray[ggm_pkg::PixW-1:0];
      end
      if (j + 1 >= w) begin
        col_pos = 0;
        row_pos = last_row ? 0 : i + 1;
      end else begin
        col_pos = j + 1;
      end
    endfunction

    function int unsigned pending();
      return pending_gradients.size();
    endfunction

    task report_mismatch(input string what);
      if (mismatches < 40) $display("MISMATCH t=%0t %s", $realtime, what);
      mismatches++;
    endtask

    task check_gradient(input gradient_t seen);
      gradient_t want;
      if (pending_gradients.size() == 0) begin
        report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                  seen.row, seen.col));
        return;
      end
      want = pending_gradients.pop_front();
      if (seen.level !== want.level)
        report_mismatch($sformatf("gradient_level (%0d,%0d): got %0d want %0d",
                                  want.row, want.col, seen.level, want.level));
      if (seen.row !== want.row)
        report_mismatch($sformatf("out_row: got %0d want %0d", seen.row, want.row));
      if (seen.col !== want.col)
        report_mismatch($sformatf("out_col: got %0d want %0d", seen.col, want.col));
      if (seen.last !== want.last)
        report_mismatch($sformatf("run_last (%0d,%0d): got %0b want %0b",
                                  want.row, want.col, seen.last, want.last));
      if (seen.done !== want.done)
        report_mismatch($sformatf("frame_done (%0d,%0d): got %0b want %0b",
                                  want.row, want.col, seen.done, want.done));
    endtask
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [ggm_pkg::CfgIdxW-1:0]    cfg_idx_i;
  logic [ggm_pkg::CfgDataW-1:0]   cfg_wdata_i;

  ggm_pix_if pix ();
  ggm_res_if grad ();

  gray_gradient_magnitude_stream DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix),
    .grad_o      (grad)
  );

  gradient_tracker tracker;
  gradient_t       seen_gradient;
  int unsigned     burst_left;
  int unsigned     pixels_sent;
  int unsigned     stall_mode;
  int unsigned     stall_cycle;
  bit              hold_off_req;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (grad.valid && grad.ready) begin
        seen_gradient.level = grad.gradient_level;
        seen_gradient.row = grad.out_row;
        seen_gradient.col = grad.out_col;
        seen_gradient.last = grad.run_last;
        seen_gradient.done = grad.frame_done;
        tracker.check_gradient(seen_gradient);
      end
      if (pix.valid && pix.ready) begin
        tracker.predict_gradients(pix.red_level, pix.green_level, pix.blue_level);
      end
    end
  end

  // receiver stall pattern, with an occasional long hold-off
  initial begin
    stall_mode = 0;
    stall_cycle = 0;
    grad.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        grad.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        stall_cycle++;
        if (stall_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: grad.ready <= 1'b1;
          1: grad.ready <= 1'($urandom_range(0, 1));
          2: grad.ready <= (stall_cycle % 4 == 0);
          default: grad.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [ggm_pkg::PixW-1:0] rand_level();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return ggm_pkg::PixW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_pixel(input logic [ggm_pkg::PixW-1:0] r,
                            input logic [ggm_pkg::PixW-1:0] g,
                            input logic [ggm_pkg::PixW-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      gap = $urandom_range(1, 6);
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red_level <= r;
    pix.green_level <= g;
    pix.blue_level <= b;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input bit set_w, input logic [ggm_pkg::CfgDataW-1:0] w_data,
                           input bit set_h, input logic [ggm_pkg::CfgDataW-1:0] h_data);
    if (set_w) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= ggm_pkg::CfgImageWidth;
      cfg_wdata_i <= w_data;
      tracker.set_reg(ggm_pkg::CfgImageWidth, w_data);
      @(posedge clk_i);
    end
    if (set_h) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= ggm_pkg::CfgImageHeight;
      cfg_wdata_i <= h_data;
      tracker.set_reg(ggm_pkg::CfgImageHeight, h_data);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // one frame in raster order, sometimes with a height change part way through
  task automatic run_frame(input int unsigned w, input int unsigned h);
    int unsigned rows, cut_row, cut_col, new_h;
    bit          cut;
    rows = h;
    cut = ($urandom_range(0, 4) == 0) && (w * h > 2);
    cut_row = $urandom_range(0, h - 1);
    cut_col = $urandom_range(0, w - 1);
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if (cut && r == cut_row && c == cut_col) begin
          wait_idle();
          new_h = $urandom_range(1, 12);
          write_cfg(1'b0, '0, 1'b1, ggm_pkg::CfgDataW'(new_h));
          rows = (r + 1 >= new_h) ? r + 1 : new_h;
        end
        send_pixel(rand_level(), rand_level(), rand_level());
      end
    end
    // restore the frame height so later frames stay aligned
    if (cut) begin
      wait_idle();
      write_cfg(1'b0, '0, 1'b1, ggm_pkg::CfgDataW'(h));
    end
  endtask

  initial begin
    int unsigned      cur_w, cur_h, frame_idx;
    logic [ggm_pkg::CfgDataW-1:0] w_data;
    tracker = new();
    burst_left = 0;
    pixels_sent = 0;
    hold_off_req = 1'b0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= ggm_pkg::CfgImageWidth;
    cfg_wdata_i <= '0;
    pix.valid <= 1'b0;
    pix.red_level <= '0;
    pix.green_level <= '0;
    pix.blue_level <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero width and height act as a single pixel frame
    write_cfg(1'b1, '0, 1'b1, '0);
    send_pixel('1, '1, '1);
    wait_idle();

    // 3x3 frame whose center gives the largest gradient
    write_cfg(1'b1, 16'd3, 1'b1, 16'd3);
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    send_pixel(8'd128, 8'd64, 8'd32);
    send_pixel('0, '0, '0);
    send_pixel(8'd10, 8'd200, 8'd90);
    send_pixel('1, '1, '1);
    send_pixel('1, '0, '0);
    send_pixel('0, '0, '0);
    send_pixel('0, '0, '1);
    wait_idle();

    // width shrinks below the current column mid-row
    write_cfg(1'b1, 16'd6, 1'b1, 16'd3);
    send_random(4);
    wait_idle();
    write_cfg(1'b1, 16'd2, 1'b0, '0);
    send_random(5);
    wait_idle();

    // tallest height, then cut below the current row
    write_cfg(1'b1, 16'd2, 1'b1, 16'hFFFF);
    send_random(4);
    wait_idle();
    write_cfg(1'b0, '0, 1'b1, 16'd2);
    send_random(2);

    frame_idx = 0;
    cur_w = 0;
    cur_h = 0;
    while (pixels_sent < RandomPixels) begin
      if (cur_w == 0 || $urandom_range(0, 2) != 0) begin
        cur_w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        cur_h = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        w_data = ggm_pkg::CfgDataW'(cur_w);
        if ($urandom_range(0, 3) == 0)
          w_data[ggm_pkg::CfgDataW-1:ggm_pkg::WidthW] =
            (ggm_pkg::CfgDataW - ggm_pkg::WidthW)'($urandom);
        wait_idle();
        write_cfg(1'b1, w_data, 1'b1, ggm_pkg::CfgDataW'(cur_h));
      end
      if (frame_idx == 3) hold_off_req = 1'b1;
      run_frame(cur_w, cur_h);
      frame_idx++;
    end

    // width register with every bit set, row ended early by a narrow width
    wait_idle();
    write_cfg(1'b1, 16'hFFFF, 1'b1, 16'd1);
    hold_off_req = 1'b1;
    send_random(WideRowPixels);
    wait_idle();
    write_cfg(1'b1, 16'd1, 1'b0, '0);
    send_random(1);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
